// ----- hw/rtl/sdrq_pkg.sv -----
// Shared ring dimensions, operation codes and port widths of the slot descriptor ring queue.
package sdrq_pkg;

    localparam int DEPTH     = 16;
    localparam int SIZE_BITS = 16;

    localparam int FUNC_W  = 3;
    localparam int SIZE_W  = SIZE_BITS;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int QLEN_W  = 5;

    localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_RESERVE     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_OLDEST = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_NEWEST = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP         = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH       = 3'd5;

endpackage

// ----- hw/rtl/slot_descriptor_ring_queue.sv -----
// Top level of the slot descriptor ring queue: sequencer, position registers and memories.
//
// A command is taken at a clock edge where start is high and busy is low. Each result is
// presented for exactly one cycle with done high, in the cycle after the sequencer forms it;
// the receiver cannot stall, so every result must be captured when done is high. Reserve,
// commit, peek oldest, pop and unknown codes first read the slot flags and descriptor
// from the synchronous memories, then update them and form the result.
// Peek newest adds a step for each discarded older entry, and flush a step for each
// drained entry, since each step rereads the memories at the new read position; flush
// delivers one free request transfer per drained pointer entry and then a closing transfer
// with last high. After reset the block runs a clearing pass over the full flags with busy
// high; queue_length writes are taken at any time through cfg_we and cfg_wdata, but should
// only be made while the block is idle. The fill count reports the true number of full
// slots, so a full ring reads its length.
module slot_descriptor_ring_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sdrq_pkg::FUNC_W-1:0]  func,
    input  logic [sdrq_pkg::SIZE_W-1:0]  item_size,
    input  logic                         item_is_pointer,
    input  logic                         cfg_we,
    input  logic [sdrq_pkg::QLEN_W-1:0]  cfg_wdata,
    output logic                         done,
    output logic                         ok,
    output logic [sdrq_pkg::IDX_W-1:0]   slot_index,
    output logic [sdrq_pkg::SIZE_W-1:0]  entry_size,
    output logic                         entry_is_pointer,
    output logic [sdrq_pkg::COUNT_W-1:0] fill_count,
    output logic                         free_request,
    output logic                         last
);

    import sdrq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int CW  = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     rpos_reg, rpos_next;
    logic [AW-1:0]     wpos_reg, wpos_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [QLEN_W-1:0] qlen_reg;
    logic              done_reg, done_next;

    // Command captured at acceptance.
    logic [FUNC_W-1:0]    func_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 ptr_reg;

    // Result payload.
    logic               ok_reg, ok_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]  esize_reg, esize_next;
    logic               eptr_reg, eptr_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic               free_reg, free_next;
    logic               last_reg, last_next;

    // Memory ports.
    logic                 flag_we, flag_wdata, flag_ra_data, flag_rb_data;
    logic [AW-1:0]        flag_waddr, flag_ra_addr, flag_rb_addr;
    logic                 desc_we, desc_rptr;
    logic [AW-1:0]        desc_raddr;
    logic [SIZE_BITS-1:0] desc_rsize;

    logic [LW-1:0] ring_len;
    logic [AW-1:0] rpos_inc, rpos_inc2, wpos_inc;
    logic [CW-1:0] count_dec;
    logic          accept;

    function automatic logic [AW-1:0] ring_step(input logic [AW-1:0] p, input logic [LW-1:0] len);
        logic [AW1-1:0] n;
        n = {1'b0, p} + AW1'(1);
        if (n >= AW1'(len))
        begin
            return '0;
        end
        return n[AW-1:0];
    endfunction

    sdrq_flag_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_flag_mem (
        .clk     (clk),
        .we      (flag_we),
        .waddr   (flag_waddr),
        .wdata   (flag_wdata),
        .raddr_a (flag_ra_addr),
        .rdata_a (flag_ra_data),
        .raddr_b (flag_rb_addr),
        .rdata_b (flag_rb_data)
    );

    sdrq_desc_mem #(
        .DEPTH     (DEPTH),
        .AW        (AW),
        .SIZE_BITS (SIZE_BITS)
    ) u_desc_mem (
        .clk   (clk),
        .we    (desc_we),
        .waddr (wpos_reg),
        .wsize (size_reg),
        .wptr  (ptr_reg),
        .raddr (desc_raddr),
        .rsize (desc_rsize),
        .rptr  (desc_rptr)
    );

    // A length of zero acts as one slot and lengths beyond the ring act as the full ring.
    always_comb
    begin
        if (qlen_reg == '0)
        begin
            ring_len = LW'(1);
        end
        else if (int'(qlen_reg) > DEPTH)
        begin
            ring_len = LW'(DEPTH);
        end
        else
        begin
            ring_len = LW'(qlen_reg);
        end
    end

    assign rpos_inc  = ring_step(rpos_reg, ring_len);
    assign rpos_inc2 = ring_step(rpos_inc, ring_len);
    assign wpos_inc  = ring_step(wpos_reg, ring_len);
    assign count_dec = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        rpos_next    = rpos_reg;
        wpos_next    = wpos_reg;
        count_next   = count_reg;
        flag_we      = 1'b0;
        flag_waddr   = rpos_reg;
        flag_wdata   = 1'b0;
        flag_ra_addr = rpos_reg;
        flag_rb_addr = rpos_inc;
        desc_we      = 1'b0;
        desc_raddr   = rpos_reg;
        done_next    = 1'b0;
        ok_next      = 1'b0;
        idx_next     = IDX_W'(rpos_reg);
        esize_next   = '0;
        eptr_next    = 1'b0;
        free_next    = 1'b0;
        last_next    = 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_waddr = clr_reg;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if ((func == FUNC_RESERVE) || (func == FUNC_COMMIT))
                begin
                    flag_ra_addr = wpos_reg;
                end
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Flag port A holds the addressed slot, port B the read slot's successor.
                unique case (func_reg)
                    FUNC_RESERVE:
                    begin
                        done_next  = 1'b1;
                        ok_next    = !flag_ra_data;
                        idx_next   = IDX_W'(wpos_reg);
                        state_next = ST_IDLE;
                    end
                    FUNC_COMMIT:
                    begin
                        done_next  = 1'b1;
                        idx_next   = IDX_W'(wpos_reg);
                        state_next = ST_IDLE;
                        if (size_reg == '0)
                        begin
                            ok_next = 1'b1;
                        end
                        else if (!flag_ra_data)
                        begin
                            ok_next    = 1'b1;
                            esize_next = SIZE_W'(size_reg);
                            eptr_next  = ptr_reg;
                            flag_we    = 1'b1;
                            flag_waddr = wpos_reg;
                            flag_wdata = 1'b1;
                            desc_we    = 1'b1;
                            wpos_next  = wpos_inc;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FUNC_POP:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (flag_ra_data)
                        begin
                            ok_next    = 1'b1;
                            esize_next = SIZE_W'(desc_rsize);
                            eptr_next  = desc_rptr;
                            flag_we    = 1'b1;
                            rpos_next  = rpos_inc;
                            count_next = count_dec;
                        end
                    end
                    FUNC_PEEK_NEWEST, FUNC_PEEK_OLDEST:
                    begin
                        if ((func_reg == FUNC_PEEK_NEWEST) && flag_ra_data && flag_rb_data
                            && (rpos_inc != rpos_reg))
                        begin
                            // Discard the older entry and reread at the new read slot.
                            flag_we      = 1'b1;
                            rpos_next    = rpos_inc;
                            count_next   = count_dec;
                            flag_ra_addr = rpos_inc;
                            flag_rb_addr = rpos_inc2;
                            desc_raddr   = rpos_inc;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                            if (flag_ra_data)
                            begin
                                ok_next    = 1'b1;
                                esize_next = SIZE_W'(desc_rsize);
                                eptr_next  = desc_rptr;
                            end
                        end
                    end
                    FUNC_FLUSH:
                    begin
                        ok_next = 1'b1;
                        if (flag_ra_data)
                        begin
                            flag_we      = 1'b1;
                            rpos_next    = rpos_inc;
                            count_next   = count_dec;
                            flag_ra_addr = rpos_inc;
                            flag_rb_addr = rpos_inc2;
                            desc_raddr   = rpos_inc;
                            done_next    = desc_rptr;
                            esize_next   = SIZE_W'(desc_rsize);
                            eptr_next    = 1'b1;
                            free_next    = 1'b1;
                            last_next    = 1'b0;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fill_next = COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rpos_reg  <= '0;
            wpos_reg  <= '0;
            count_reg <= '0;
            qlen_reg  <= QLEN_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rpos_reg  <= rpos_next;
            wpos_reg  <= wpos_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                qlen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            size_reg <= SIZE_BITS'(item_size);
            ptr_reg  <= item_is_pointer;
        end
        if (done_next)
        begin
            ok_reg    <= ok_next;
            idx_reg   <= idx_next;
            esize_reg <= esize_next;
            eptr_reg  <= eptr_next;
            fill_reg  <= fill_next;
            free_reg  <= free_next;
            last_reg  <= last_next;
        end
    end

    assign done             = done_reg;
    assign ok               = ok_reg;
    assign slot_index       = idx_reg;
    assign entry_size       = esize_reg;
    assign entry_is_pointer = eptr_reg;
    assign fill_count       = fill_reg;
    assign free_request     = free_reg;
    assign last             = last_reg;

endmodule

// ----- hw/rtl/sdrq_flag_mem.sv -----
// Slot full-flag memory: one write port, two registered read ports with write forwarding.
module sdrq_flag_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr_a,
    output logic          rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic          rdata_b
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the entry written at the same edge returns the new value.
    always_ff @(posedge clk)
    begin
        rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
        rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end

endmodule

// ----- hw/rtl/sdrq_desc_mem.sv -----
// Slot descriptor memory holding the byte size and pointer flag of each slot.
module sdrq_desc_mem #(
    parameter int DEPTH     = 16,
    parameter int AW        = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [SIZE_BITS-1:0] wsize,
    input  logic                 wptr,
    input  logic [AW-1:0]        raddr,
    output logic [SIZE_BITS-1:0] rsize,
    output logic                 rptr
);

    logic [SIZE_BITS:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wptr, wsize};
        end
    end

    always_ff @(posedge clk)
    begin
        {rptr, rsize} <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sdrq_checker.sv -----
// Port-level assertions of the slot descriptor ring queue and their bind to the top level.
module sdrq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         ok,
    input logic                         entry_is_pointer,
    input logic                         free_request,
    input logic                         last,
    input logic [sdrq_pkg::COUNT_W-1:0] fill_count
);

    import sdrq_pkg::*;

    // An accepted command keeps the block busy for at least its execute cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command transfer");

    // No result can appear in the cycle right after a command is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result transfer in the cycle after command acceptance");

    // Only flush free requests may precede the final result of a command.
    a_nonlast_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (free_request && ok && entry_is_pointer))
        else $error("non-final result is not a pointer free request");

    // The final result of a command never asks for a free.
    a_last_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !free_request)
        else $error("final result carries a free request");

    // The ring can never report more full entries than it has slots.
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fill_count <= COUNT_W'(DEPTH)))
        else $error("fill count beyond the ring depth");

endmodule

bind slot_descriptor_ring_queue sdrq_checker u_sdrq_checker (.*);
